FILE: hw/rtl/iss_pkg.sv
// iss_pkg: types and constants for the idle shutdown session tracker
// used by iss_cfg, idle_shutdown_session_tracker and the testbench; no dependencies
package iss_pkg;

    localparam int TIMER_W = 24;
    localparam int CNT_W   = 9;
    localparam int SLOT_W  = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef enum logic [2:0] {
        MODE_INITIAL          = 3'd0,
        MODE_HAS_CLIENTS      = 3'd1,
        MODE_LOSS_PENDING     = 3'd2,
        MODE_SHUTDOWN_PENDING = 3'd3,
        MODE_HALTED           = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_EXEC
    } t_seq;

    typedef enum logic {
        OP_EVENT = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic {
        REG_LOSS_TICKS     = 1'b0,
        REG_SHUTDOWN_TICKS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [TIMER_W-1:0] loss_ticks;
        logic [TIMER_W-1:0] shutdown_ticks;
    } t_cfg;

endpackage

FILE: hw/rtl/idle_shutdown_session_tracker.sv
// idle_shutdown_session_tracker: top level, sequencer, count, mode and countdowns
// depends on iss_pkg, iss_cfg, iss_map_mem
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | to block  | i_valid / o_stall   | i_op, i_client_index, i_client_gone
//  out     | from block| o_valid / i_stall   | o_control_taken, o_shutdown,
//          |           |                     | o_spurious_disconnect, o_mode,
//          |           |                     | o_clients_connected
//  cfg     | to block  | psel/penable/pready | paddr, pwdata, prdata
//
// an item is accepted in the idle state, which starts the map memory read; the exec
// state then commits the update and loads the result register; the map memory read is
// registered, so no new item is taken until the previous one has committed
// after reset a sweep clears all MAX_CLIENTS slots; o_stall falls the cycle after it ends
// a new item is taken while a result still waits; its commit waits on i_stall
module idle_shutdown_session_tracker #(
    parameter int MAX_CLIENTS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [iss_pkg::SLOT_W-1:0]   i_client_index,
    input  logic                         i_client_gone,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_control_taken,
    output logic                         o_shutdown,
    output logic                         o_spurious_disconnect,
    output iss_pkg::t_mode               o_mode,
    output logic [iss_pkg::CNT_W-1:0]    o_clients_connected,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iss_pkg::APB_AW-1:0]   paddr,
    input  logic [iss_pkg::APB_DW-1:0]   pwdata,
    output logic [iss_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import iss_pkg::*;

    localparam int   AW             = $clog2(MAX_CLIENTS);
    localparam logic SLOT_ALL_VALID = (MAX_CLIENTS >= (1 << SLOT_W));

    t_cfg               cfg;
    logic               clr_busy;
    logic               map_bit;

    t_seq               r_seq, n_seq;
    t_op                r_op;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_gone;
    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TIMER_W-1:0] r_loss_timer, n_loss_timer;
    logic [TIMER_W-1:0] r_shut_timer, n_shut_timer;
    logic               r_out_valid, n_out_valid;
    logic               r_out_taken, n_out_taken;
    logic               r_out_down, n_out_down;
    logic               r_out_spur, n_out_spur;

    logic               accept;
    logic               exec_go;
    logic               in_range;
    logic               wr_en;
    logic               wr_data;

    iss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    iss_map_mem #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_map_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_client_index)),
        .o_rd_data (map_bit),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_slot)),
        .i_wr_data (wr_data),
        .o_busy    (clr_busy)
    );

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SEQ_CLEAR: if (!clr_busy) n_seq = SEQ_IDLE;
            SEQ_IDLE:  if (i_valid)   n_seq = SEQ_EXEC;
            SEQ_EXEC:  if (exec_go)   n_seq = SEQ_IDLE;
            default:   n_seq = SEQ_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall = (r_seq != SEQ_IDLE);
        accept  = (r_seq == SEQ_IDLE) && i_valid;
        exec_go = (r_seq == SEQ_EXEC) && (!r_out_valid || !i_stall);
    end

    assign in_range = SLOT_ALL_VALID || (r_slot < SLOT_W'(MAX_CLIENTS));

    // read-modify-write of the map and the scalar state
    always_comb begin
        n_mode       = r_mode;
        n_count      = r_count;
        n_loss_timer = r_loss_timer;
        n_shut_timer = r_shut_timer;
        n_out_taken  = 1'b0;
        n_out_down   = 1'b0;
        n_out_spur   = 1'b0;
        wr_en        = 1'b0;
        wr_data      = 1'b0;
        if (r_mode != MODE_HALTED) begin
            if (r_op == OP_TICK) begin
                case (r_mode)
                    MODE_LOSS_PENDING: begin
                        if (r_loss_timer != '0) begin
                            n_loss_timer = r_loss_timer - TIMER_W'(1);
                        end
                        if (r_loss_timer[TIMER_W-1:1] == '0) begin
                            n_out_taken  = 1'b1;
                            n_shut_timer = cfg.shutdown_ticks;
                            n_mode       = MODE_SHUTDOWN_PENDING;
                        end
                    end
                    MODE_SHUTDOWN_PENDING: begin
                        if (r_shut_timer == '0) begin
                            n_out_down = 1'b1;
                            n_mode     = MODE_HALTED;
                        end else begin
                            n_shut_timer = r_shut_timer - TIMER_W'(1);
                        end
                    end
                    default: ;
                endcase
            end else if (in_range) begin
                if (r_gone) begin
                    if (!map_bit) begin
                        n_out_spur = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                        if (n_count == '0 && r_mode == MODE_HAS_CLIENTS) begin
                            n_loss_timer = cfg.loss_ticks;
                            n_mode       = MODE_LOSS_PENDING;
                        end
                    end
                end else if (!map_bit) begin
                    wr_en   = 1'b1;
                    wr_data = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_mode  = MODE_HAS_CLIENTS;
                end
            end
        end
        wr_en = wr_en && exec_go;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (exec_go) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SEQ_CLEAR;
            r_mode       <= MODE_INITIAL;
            r_count      <= '0;
            r_loss_timer <= '0;
            r_shut_timer <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            if (exec_go) begin
                r_mode       <= n_mode;
                r_count      <= n_count;
                r_loss_timer <= n_loss_timer;
                r_shut_timer <= n_shut_timer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_op);
            r_slot <= i_client_index;
            r_gone <= i_client_gone;
        end
        if (exec_go) begin
            r_out_taken <= n_out_taken;
            r_out_down  <= n_out_down;
            r_out_spur  <= n_out_spur;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_control_taken       = r_out_taken;
    assign o_shutdown            = r_out_down;
    assign o_spurious_disconnect = r_out_spur;
    assign o_mode                = r_mode;
    assign o_clients_connected   = r_count;

    // no client may be counted once the countdowns are running or the tracker is halted
    a_count_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_LOSS_PENDING || r_mode == MODE_SHUTDOWN_PENDING ||
         r_mode == MODE_HALTED) |-> (r_count == '0))
        else $error("client count nonzero while a countdown or halt is active");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) <= 32'(MAX_CLIENTS)))
        else $error("client count above slot count");

    a_map_write_at_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_seq == SEQ_EXEC && !clr_busy))
        else $error("map written outside a commit");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_control_taken && o_shutdown))
        else $error("control and shutdown pulses in one beat");

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_seq == SEQ_EXEC))
        else $error("accepted beat not followed by its commit cycle");

endmodule

FILE: hw/rtl/iss_cfg.sv
// iss_cfg: APB-style register file holding the two countdown reload values
// depends on iss_pkg
module iss_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iss_pkg::APB_AW-1:0]   paddr,
    input  logic [iss_pkg::APB_DW-1:0]   pwdata,
    output logic [iss_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output iss_pkg::t_cfg                o_cfg
);
    import iss_pkg::*;

    logic [TIMER_W-1:0] r_loss_ticks;
    logic [TIMER_W-1:0] r_shutdown_ticks;
    t_reg_idx           reg_idx;
    logic               wr_go;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_go   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_ticks     <= '0;
            r_shutdown_ticks <= '0;
        end else if (wr_go) begin
            unique case (reg_idx)
                REG_LOSS_TICKS:     r_loss_ticks     <= pwdata[TIMER_W-1:0];
                REG_SHUTDOWN_TICKS: r_shutdown_ticks <= pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LOSS_TICKS:     prdata = APB_DW'(r_loss_ticks);
            REG_SHUTDOWN_TICKS: prdata = APB_DW'(r_shutdown_ticks);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.loss_ticks     = r_loss_ticks;
    assign o_cfg.shutdown_ticks = r_shutdown_ticks;

endmodule

FILE: hw/rtl/iss_map_mem.sv
// iss_map_mem: one-bit-per-slot connected map in a synchronous memory
// with a clearing sweep after reset; no package dependencies
module iss_map_mem #(
    parameter int MAX_CLIENTS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_CLIENTS)-1:0] i_rd_addr,
    output logic                           o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_CLIENTS)-1:0] i_wr_addr,
    input  logic                           i_wr_data,
    output logic                           o_busy
);
    localparam int AW = $clog2(MAX_CLIENTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CLIENTS - 1);

    logic          mem [MAX_CLIENTS];
    logic [AW-1:0] r_clr_addr;
    logic          r_busy;
    logic          r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_busy     <= 1'b1;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: tb/testbench.sv
// testbench: self-checking bench for idle_shutdown_session_tracker with a
// built-in session tracker model, randomized beats and stalls, and per-phase register writes
// depends on iss_pkg and idle_shutdown_session_tracker
module testbench;
    import iss_pkg::*;

    localparam int SLOTS = 256;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam logic [TIMER_W-1:0] TICKS_MAX = '1;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic              gone;
    } t_event;

    typedef struct packed {
        logic             taken;
        logic             down;
        logic             spurious;
        t_mode            mode;
        logic [CNT_W-1:0] count;
    } t_status;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_op = 1'b0;
    logic [SLOT_W-1:0]  i_client_index = '0;
    logic               i_client_gone = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_control_taken;
    logic               o_shutdown;
    logic               o_spurious_disconnect;
    t_mode              o_mode;
    logic [CNT_W-1:0]   o_clients_connected;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    idle_shutdown_session_tracker #(.MAX_CLIENTS(SLOTS)) dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // session model state
    logic               present [SLOTS] = '{default: 1'b0};
    logic [CNT_W-1:0]   head_count = '0;
    t_mode              sess_mode = MODE_INITIAL;
    logic [TIMER_W-1:0] loss_left = '0;
    logic [TIMER_W-1:0] down_left = '0;
    logic [TIMER_W-1:0] cfg_loss = '0;
    logic [TIMER_W-1:0] cfg_down = '0;

    t_event  event_q [$];
    t_status status_q [$];
    bit      plan_map [SLOTS] = '{default: 1'b0};
    int      plan_conn [$];
    int      pool [3];

    int n_pushed = 0;
    int n_taken = 0;
    int n_results = 0;
    int n_bad = 0;
    int n_phases = 0;
    int n_control = 0;
    int n_shutdown = 0;
    int n_spurious = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_epoch = 0;
    int quiet = 0;
    logic in_took = 1'b0;

    function automatic t_status track_session(t_op op, logic [SLOT_W-1:0] slot, logic gone);
        t_status r;
        logic [TIMER_W-1:0] prior;
        r = '0;
        if (sess_mode != MODE_HALTED) begin
            if (op == OP_TICK) begin
                if (sess_mode == MODE_LOSS_PENDING) begin
                    prior = loss_left;
                    loss_left = (prior != 0) ? prior - 1'b1 : '0;
                    if (prior <= 1) begin
                        r.taken = 1'b1;
                        down_left = cfg_down;
                        sess_mode = MODE_SHUTDOWN_PENDING;
                    end
                end else if (sess_mode == MODE_SHUTDOWN_PENDING) begin
                    if (down_left == 0) begin
                        r.down = 1'b1;
                        sess_mode = MODE_HALTED;
                    end else begin
                        down_left = down_left - 1'b1;
                    end
                end
            end else if (int'(slot) < SLOTS) begin
                if (gone) begin
                    if (!present[slot]) begin
                        r.spurious = 1'b1;
                    end else begin
                        present[slot] = 1'b0;
                        if (head_count > 0) head_count = head_count - 1'b1;
                        if (head_count == 0 && sess_mode == MODE_HAS_CLIENTS) begin
                            loss_left = cfg_loss;
                            sess_mode = MODE_LOSS_PENDING;
                        end
                    end
                end else if (!present[slot]) begin
                    present[slot] = 1'b1;
                    head_count = head_count + 1'b1;
                    sess_mode = MODE_HAS_CLIENTS;
                end
            end
        end
        r.mode = sess_mode;
        r.count = head_count;
        return r;
    endfunction

    task automatic flag_mismatch(string what, t_status want, t_status got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("mismatch (%s): expected taken=%0b down=%0b spurious=%0b mode=%0d count=%0d",
                     what, want.taken, want.down, want.spurious, want.mode, want.count);
            $display("    got taken=%0b down=%0b spurious=%0b mode=%0d count=%0d",
                     got.taken, got.down, got.spurious, got.mode, got.count);
        end
    endtask

    // result checking and prediction on accepted beats
    always @(posedge i_clk) begin
        t_status got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_control_taken, o_shutdown, o_spurious_disconnect, o_mode,
                    o_clients_connected};
            n_results++;
            n_control += got.taken;
            n_shutdown += got.down;
            n_spurious += got.spurious;
            if (status_q.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, got);
            end else begin
                want = status_q.pop_front();
                if (got.taken !== want.taken || got.down !== want.down ||
                    got.spurious !== want.spurious || got.mode !== want.mode ||
                    got.count !== want.count)
                    flag_mismatch("wrong field", want, got);
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            status_q.push_back(track_session(t_op'(i_op), i_client_index, i_client_gone));
            n_taken++;
        end
        in_took <= i_rst_n && i_valid && !o_stall;
    end

    always @(negedge i_clk) begin
        t_event ev;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_took) begin
            if (event_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                ev = event_q.pop_front();
                i_valid <= 1'b1;
                i_op <= ev.op;
                i_client_index <= ev.slot;
                i_client_gone <= ev.gone;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stalls, with a long hold-off when a phase asks for one
    always @(negedge i_clk) begin
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_epoch) begin
            hold_seen = hold_epoch;
            hold_left = HOLD_CYCLES;
        end
        i_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_stall_pct);
        if (hold_left > 0) hold_left--;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [TIMER_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {8'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LOSS_TICKS) cfg_loss = value;
        else cfg_down = value;
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (n_taken != n_pushed || status_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_item(t_op op, int slot, logic gone);
        t_event ev;
        int j;
        ev.op = op;
        ev.slot = SLOT_W'(slot);
        ev.gone = gone;
        event_q.push_back(ev);
        n_pushed++;
        if (op == OP_EVENT) begin
            if (gone && plan_map[slot]) begin
                plan_map[slot] = 1'b0;
                for (j = 0; j < plan_conn.size(); j++) begin
                    if (plan_conn[j] == slot) begin
                        plan_conn.delete(j);
                        break;
                    end
                end
            end else if (!gone && !plan_map[slot]) begin
                plan_map[slot] = 1'b1;
                plan_conn.push_back(slot);
            end
        end
    endtask

    task automatic queue_random(int n);
        int roll;
        int k;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                push_item(OP_TICK, $urandom_range(SLOTS - 1), 1'($urandom_range(1)));
            end else if (roll < 60) begin
                push_item(OP_EVENT, pool[$urandom_range(2)], 1'b0);
            end else if (roll < 68) begin
                push_item(OP_EVENT, $urandom_range(SLOTS - 1), 1'b0);
            end else if (roll < 92 && plan_conn.size() != 0) begin
                k = $urandom_range(plan_conn.size() - 1);
                push_item(OP_EVENT, plan_conn[k], 1'b1);
            end else begin
                push_item(OP_EVENT, $urandom_range(SLOTS - 1), 1'b1);
            end
        end
    endtask

    task automatic start_phase(logic [TIMER_W-1:0] loss, logic [TIMER_W-1:0] down,
                               int send_pct, int stall_pct, bit hold);
        int k;
        settle();
        write_reg(REG_LOSS_TICKS, loss);
        write_reg(REG_SHUTDOWN_TICKS, down);
        @(posedge i_clk);
        sender_idle_pct = send_pct;
        receiver_stall_pct = stall_pct;
        if (hold) hold_epoch++;
        for (k = 0; k < 3; k++) pool[k] = $urandom_range(SLOTS - 1);
        n_phases++;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        start_phase(24'd2, TICKS_MAX, 0, 0, 1'b0);
        push_item(OP_TICK, 0, 1'b0);
        push_item(OP_EVENT, 0, 1'b1);
        push_item(OP_EVENT, 0, 1'b0);
        push_item(OP_EVENT, 255, 1'b0);
        push_item(OP_EVENT, 0, 1'b0);
        push_item(OP_EVENT, 128, 1'b1);
        push_item(OP_TICK, 255, 1'b1);
        push_item(OP_EVENT, 0, 1'b1);
        push_item(OP_EVENT, 255, 1'b1);
        push_item(OP_TICK, 0, 1'b0);
        push_item(OP_TICK, 0, 1'b0);
        push_item(OP_TICK, 0, 1'b0);
        push_item(OP_EVENT, 5, 1'b1);
        push_item(OP_EVENT, 170, 1'b0);
        push_item(OP_EVENT, 85, 1'b0);
        push_item(OP_EVENT, 170, 1'b1);
        push_item(OP_EVENT, 85, 1'b1);
        push_item(OP_EVENT, 1, 1'b0);
        push_item(OP_EVENT, 1, 1'b1);
        push_item(OP_TICK, 0, 1'b0);

        start_phase(24'd0, TICKS_MAX, 0, 0, 1'b0);
        queue_random(115);
        start_phase(24'd3, 24'd40, 70, 0, 1'b0);
        queue_random(115);
        start_phase(TICKS_MAX, 24'd1000, 0, 70, 1'b0);
        queue_random(115);
        start_phase(24'd1, TICKS_MAX, 22, 22, 1'b1);
        queue_random(115);
        start_phase(24'd2, TICKS_MAX, 0, 0, 1'b1);
        queue_random(115);
        start_phase(24'd4, 24'd200000, 22, 22, 1'b0);
        queue_random(115);

        // drain to the last disconnect, expire both countdowns, then halted
        start_phase(24'd0, 24'd0, 0, 70, 1'b0);
        push_item(OP_EVENT, 7, 1'b0);
        while (plan_conn.size() != 0) push_item(OP_EVENT, plan_conn[0], 1'b1);
        push_item(OP_TICK, 0, 1'b0);
        push_item(OP_TICK, 0, 1'b0);
        push_item(OP_EVENT, 3, 1'b0);
        push_item(OP_EVENT, 3, 1'b1);
        push_item(OP_TICK, 0, 1'b0);
        queue_random(15);

        settle();
        repeat (8) @(negedge i_clk);
        $display("run: %0d beats over %0d register settings, %0d results checked",
                 n_pushed, n_phases, n_results);
        $display("seen: %0d control losses, %0d shutdowns, %0d spurious disconnects",
                 n_control, n_shutdown, n_spurious);
        if (n_bad == 0 && status_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/iss_pkg.sv
hw/rtl/iss_cfg.sv
hw/rtl/iss_map_mem.sv
hw/rtl/idle_shutdown_session_tracker.sv
tb/testbench.sv
